### src/cwn_pkg.sv
`default_nettype none

package cwn_pkg;

    localparam int SUM_W = 48;
    localparam int CNT_W = 16;
    localparam int Q_W   = 32;
    localparam int ID_W  = 8;

    localparam logic [1:0] REQ_ACC   = 2'd0;
    localparam logic [1:0] REQ_NORM  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [SUM_W-1:0] ONE_Q16   = 48'h0000_0001_0000;
    localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;
    localparam logic [Q_W-1:0]   SAT_POS   = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0]   SAT_NEG   = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]             req_type;
        logic signed [Q_W-1:0]  weight;
        logic [ID_W-1:0]        cluster_id;
    } cwn_in_t;

    typedef struct packed {
        logic signed [Q_W-1:0]  factor;
        logic                   label_error;
        logic                   used_count;
    } cwn_out_t;

    typedef struct packed {
        logic [Q_W-1:0] quotient;
        logic           overflow;
    } cwn_div_res_t;

endpackage

`default_nettype wire

### src/cwn_store.sv
`default_nettype none

module cwn_store #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        clr,
    input  wire logic                        rd_en,
    input  wire logic [IDX_W-1:0]            rd_addr,
    input  wire logic                        wr_en,
    input  wire logic [IDX_W-1:0]            wr_addr,
    input  wire logic [cwn_pkg::SUM_W-1:0]   wr_sum,
    input  wire logic [cwn_pkg::CNT_W-1:0]   wr_cnt,
    output logic      [cwn_pkg::SUM_W-1:0]   rd_sum,
    output logic      [cwn_pkg::CNT_W-1:0]   rd_cnt
);
    import cwn_pkg::*;

    logic [SUM_W-1:0] sum_mem [DEPTH];
    logic [CNT_W-1:0] cnt_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [SUM_W-1:0] rd_sum_reg;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic             rd_valid_reg;

    // An entry whose valid bit is clear reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sum_mem[wr_addr] <= wr_sum;
            cnt_mem[wr_addr] <= wr_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_sum_reg   <= sum_mem[rd_addr];
            rd_cnt_reg   <= cnt_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_sum = rd_valid_reg ? rd_sum_reg : '0;
    assign rd_cnt = rd_valid_reg ? rd_cnt_reg : '0;

endmodule

`default_nettype wire

### src/cwn_div.sv
`default_nettype none

module cwn_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [cwn_pkg::SUM_W-1:0]   dividend,
    input  wire logic [cwn_pkg::SUM_W-1:0]   divisor,
    output logic                             done,
    output cwn_pkg::cwn_div_res_t            res
);
    import cwn_pkg::*;

    localparam int STEP_W = $clog2(Q_W);

    logic               busy_reg;
    logic               done_reg;
    logic               ovf_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [SUM_W-1:0]   rem_reg;
    logic [SUM_W-1:0]   dvs_reg;
    logic [Q_W-1:0]     quo_reg;
    logic [SUM_W:0]     trial;
    logic [SUM_W-1:0]   diff;
    logic               ge;

    // One quotient bit per cycle; the low dividend bits shift out as quotient bits shift in.
    assign trial = {rem_reg, quo_reg[Q_W-1]};
    assign diff  = trial[SUM_W-1:0] - dvs_reg;
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(Q_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {{Q_W{1'b0}}, dividend[SUM_W-1:Q_W]};
            quo_reg <= dividend[Q_W-1:0];
            dvs_reg <= divisor;
            ovf_reg <= {{Q_W{1'b0}}, dividend[SUM_W-1:Q_W]} >= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff : trial[SUM_W-1:0];
            quo_reg <= {quo_reg[Q_W-2:0], ge};
        end
    end

    assign done         = done_reg;
    assign res.quotient = quo_reg;
    assign res.overflow = ovf_reg;

endmodule

`default_nettype wire

### src/cluster_weight_normalizer.sv
`default_nettype none

// Channel   Ports                        Beat
// input     s_valid s_ready s_data       req_type, weight, cluster_id
// result    m_valid m_ready m_data       factor, label_error, used_count
//
// Clear and unused requests stay in IDLE; accumulate passes READ, a bad label OUT.
// A normalize passes READ, START, DIV (32 radix-2 divider steps) and OUT.
// Reset (synchronous, active low) empties the output register and all cluster sums.
// A result waits in the output register while the next beat is taken.

module cluster_weight_normalizer #(
    parameter int MAX_CLUSTERS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire cwn_pkg::cwn_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output cwn_pkg::cwn_out_t      m_data
);
    import cwn_pkg::*;

    localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_START = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         req_reg;
    logic [Q_W-1:0]     w_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [SUM_W-1:0]   dvd_reg, dvd_next;
    logic [SUM_W-1:0]   dvs_reg, dvs_next;
    logic               neg_reg, neg_next;
    logic               used_reg, used_next;
    cwn_out_t           res_reg, res_next;
    cwn_out_t           m_data_reg;
    logic               m_valid_reg;

    logic               accept;
    logic               bad;
    logic [ID_W-1:0]    id_m1;
    logic               clr;
    logic               rd_en;
    logic               wr_en;
    logic [SUM_W-1:0]   wr_sum;
    logic [CNT_W-1:0]   wr_cnt;
    logic [SUM_W-1:0]   rd_sum;
    logic [CNT_W-1:0]   rd_cnt;
    logic [SUM_W-1:0]   w48;
    logic [Q_W-1:0]     wmag;
    logic [SUM_W-1:0]   smag;
    logic               div_start;
    logic               div_done;
    cwn_div_res_t       div_res;
    logic               big;
    logic [Q_W-1:0]     sat;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign bad = (s_data.cluster_id == '0) ||
                 ({1'b0, s_data.cluster_id} > 9'(MAX_CLUSTERS));
    assign id_m1 = s_data.cluster_id - 1'b1;

    assign w48  = {{(SUM_W - Q_W){w_reg[Q_W-1]}}, w_reg};
    assign wmag = w_reg[Q_W-1] ? (~w_reg + 1'b1) : w_reg;
    assign smag = rd_sum[SUM_W-1] ? (~rd_sum + 1'b1) : rd_sum;

    assign wr_sum = rd_sum + w48;
    assign wr_cnt = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;

    assign big = div_res.overflow || div_res.quotient[Q_W-1];
    always_comb begin
        if (neg_reg && (div_res.overflow || div_res.quotient != '0)) begin
            sat = big ? SAT_NEG : (~div_res.quotient + 1'b1);
        end else begin
            sat = big ? SAT_POS : div_res.quotient;
        end
    end

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        used_next  = used_reg;
        clr        = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.req_type == REQ_CLEAR) begin
                        clr = 1'b1;
                    end else if (s_data.req_type == REQ_ACC ||
                                 s_data.req_type == REQ_NORM) begin
                        if (bad) begin
                            res_next = '{factor: '0, label_error: 1'b1, used_count: 1'b0};
                            state_next = ST_OUT;
                        end else begin
                            rd_en = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                if (req_reg == REQ_ACC) begin
                    wr_en = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    if (rd_sum == '0) begin
                        dvd_next  = ONE_Q16;
                        dvs_next  = (rd_cnt == '0) ? SUM_W'(1) : SUM_W'(rd_cnt);
                        neg_next  = 1'b0;
                        used_next = 1'b1;
                    end else begin
                        dvd_next  = {wmag, 16'h0000};
                        dvs_next  = smag;
                        neg_next  = w_reg[Q_W-1] ^ rd_sum[SUM_W-1];
                        used_next = 1'b0;
                    end
                    state_next = ST_START;
                end
            end
            ST_START: begin
                div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    res_next = '{factor: sat, label_error: 1'b0, used_count: used_reg};
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_data.req_type;
            w_reg   <= s_data.weight;
            idx_reg <= id_m1[IDX_W-1:0];
        end
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        used_reg <= used_next;
        res_reg  <= res_next;
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_data_reg <= res_reg;
        end
    end

    cwn_store #(
        .DEPTH (MAX_CLUSTERS),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (clr),
        .rd_en   (rd_en),
        .rd_addr (id_m1[IDX_W-1:0]),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_sum  (wr_sum),
        .wr_cnt  (wr_cnt),
        .rd_sum  (rd_sum),
        .rd_cnt  (rd_cnt)
    );

    cwn_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .res      (div_res)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
